// File: hdl/bmpru_pkg.sv
// ----------------------------------------------------------------------------
// bmpru_pkg
// Shared types and codes for the BMP pixel row unpacker: pixel formats and
// configuration register indexes.
// ----------------------------------------------------------------------------
package bmpru_pkg;

    typedef enum logic [1:0] {
        FMT_RGB565 = 2'd0,
        FMT_BGR24  = 2'd1,
        FMT_BGRA32 = 2'd2
    } fmt_t;

    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd2;

    localparam int CFG_DATA_W = 13;
    localparam int FMT_W      = 2;

endpackage

// File: hdl/bmpru_convert.sv
// ----------------------------------------------------------------------------
// bmpru_convert
// Builds the 32-bit texture pixel from the gathered source bytes and the
// final byte of the pixel, per the configured source format.
// ----------------------------------------------------------------------------
module bmpru_convert
    import bmpru_pkg::*;
(
    input  logic [FMT_W-1:0] pixel_format,
    input  logic [23:0]      gather,
    input  logic [7:0]       final_byte,
    output logic [31:0]      pixel_word
);

    // floor(x * 255 / 31) = 8x + floor(7x / 31); 7x / 31 by reciprocal 265 / 8192
    function automatic logic [7:0] widen5(input logic [4:0] x);
        logic [7:0]  n;
        logic [16:0] prod;
        n    = 8'(x) * 8'd7;
        prod = 17'(n) * 17'd265;
        return {x, 3'b000} + 8'(prod[16:13]);
    endfunction

    // floor(x * 255 / 63) = 4x + floor(x / 21)
    function automatic logic [7:0] widen6(input logic [5:0] x);
        logic [1:0] q;
        q = 2'(x >= 6'd21) + 2'(x >= 6'd42) + 2'(x >= 6'd63);
        return {x, 2'b00} + 8'(q);
    endfunction

    logic [15:0] v565;

    assign v565 = {final_byte, gather[7:0]};

    always_comb
    begin
        case (pixel_format)
            FMT_RGB565:
            begin
                pixel_word = {8'hFF, widen5(v565[4:0]), widen6(v565[10:5]),
                              widen5(v565[15:11])};
            end
            FMT_BGR24:
            begin
                pixel_word = {8'hFF, gather[7:0], gather[15:8], final_byte};
            end
            default:
            begin
                pixel_word = {final_byte, gather[7:0], gather[15:8], gather[23:16]};
            end
        endcase
    end

endmodule

// File: hdl/bmp_pixel_row_unpacker.sv
// ----------------------------------------------------------------------------
// bmp_pixel_row_unpacker
// Converts the bottom-up pixel area of a BMP image, one byte per item, into
// 32-bit texture pixels tagged with column, top-down row and last pixel.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while data_ready is high, padding
// bytes included. The pixel finished by an accepted byte moves from the input
// register to the output register when that is free. The input and output
// registers are each one stage deep, so data_ready drops only while the final
// byte of a pixel waits in the input register behind a pixel that the sink
// has not yet taken. Each pixel costs 2, 3 or 4 input items by format, each
// row end the padding bytes up to a 4-byte boundary. A configuration write
// is taken in any cycle and restarts the image from its bottom row.
module bmp_pixel_row_unpacker
    import bmpru_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  data_valid,
    output logic                  data_ready,
    input  logic [7:0]            data_byte,
    output logic                  pixel_valid,
    input  logic                  pixel_ready,
    output logic [31:0]           pixel_word,
    output logic [11:0]           column,
    output logic [11:0]           row,
    output logic                  last_pixel
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1) > 0 ? $clog2(MAX_WIDTH + 1) : 1;
    localparam int HW = $clog2(MAX_HEIGHT + 1) > 0 ? $clog2(MAX_HEIGHT + 1) : 1;

    logic [CFG_DATA_W-1:0] width_cfg_reg;
    logic [CFG_DATA_W-1:0] height_cfg_reg;
    logic [FMT_W-1:0]      format_reg;

    logic [23:0]   gather_reg,  gather_next;
    logic [1:0]    index_reg,   index_next;
    logic [CW-1:0] col_reg,     col_next;
    logic [1:0]    pad_reg,     pad_next;
    logic [RW-1:0] src_row_reg, src_row_next;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] pixel_word_reg;
    logic [11:0] column_reg;
    logic [11:0] row_reg;
    logic        last_reg;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [2:0]    bpp;
    logic          gathering;
    logic          produce;
    logic          out_open;
    logic          in_fire;
    logic          in_take;
    logic          cfg_take;
    logic          col_last;
    logic          row_last;
    logic [HW-1:0] row_calc;
    logic [31:0]   row_ext;
    logic [31:0]   col_ext;
    logic [1:0]    w_lo;
    logic [31:0]   pixel_calc;

    // clamp sizes to 1..MAX
    always_comb
    begin
        if (width_cfg_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(width_cfg_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_cfg_reg);
        end

        if (height_cfg_reg == '0)
        begin
            h_eff = HW'(1);
        end
        else if (32'(height_cfg_reg) > 32'(MAX_HEIGHT))
        begin
            h_eff = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HW'(height_cfg_reg);
        end
    end

    always_comb
    begin
        case (format_reg)
            FMT_RGB565: bpp = 3'd2;
            FMT_BGR24:  bpp = 3'd3;
            default:    bpp = 3'd4;
        endcase
    end

    assign w_lo = 2'(w_eff);

    assign gathering = (3'(index_reg) + 3'd1) < bpp;
    assign produce   = in_valid_reg && (pad_reg == 2'd0) && !gathering;
    assign out_open  = !out_valid_reg || pixel_ready;
    assign in_fire   = in_valid_reg && (!produce || out_open);
    assign data_ready = !in_valid_reg || in_fire;
    assign in_take   = data_valid && data_ready;
    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid &&
                       ((cfg_index == CFG_IMAGE_WIDTH) || (cfg_index == CFG_IMAGE_HEIGHT) ||
                        (cfg_index == CFG_PIXEL_FORMAT));

    assign col_last = (WW'(col_reg) + WW'(1)) >= w_eff;
    assign row_last = (HW'(src_row_reg) + HW'(1)) >= h_eff;
    assign row_calc = h_eff - HW'(1) - HW'(src_row_reg);
    assign row_ext  = 32'(row_calc);
    assign col_ext  = 32'(col_reg);

    bmpru_convert u_convert
    (
        .pixel_format (format_reg),
        .gather       (gather_reg),
        .final_byte   (in_byte_reg),
        .pixel_word   (pixel_calc)
    );

    // stream state
    always_comb
    begin
        gather_next  = gather_reg;
        index_next   = index_reg;
        col_next     = col_reg;
        pad_next     = pad_reg;
        src_row_next = src_row_reg;

        if (cfg_take)
        begin
            gather_next  = '0;
            index_next   = '0;
            col_next     = '0;
            pad_next     = '0;
            src_row_next = '0;
        end
        else if (in_fire)
        begin
            if (pad_reg != 2'd0)
            begin
                pad_next = pad_reg - 2'd1;
            end
            else if (gathering)
            begin
                case (index_reg)
                    2'd0:    gather_next[7:0]   = in_byte_reg;
                    2'd1:    gather_next[15:8]  = in_byte_reg;
                    2'd2:    gather_next[23:16] = in_byte_reg;
                    default: gather_next        = gather_reg;
                endcase
                index_next = index_reg + 2'd1;
            end
            else
            begin
                gather_next = '0;
                index_next  = '0;
                if (col_last)
                begin
                    col_next = '0;
                    case (format_reg)
                        FMT_RGB565: pad_next = {w_lo[0], 1'b0};
                        FMT_BGR24:  pad_next = w_lo;
                        default:    pad_next = 2'd0;
                    endcase
                    src_row_next = row_last ? '0 : src_row_reg + RW'(1);
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
        end
    end

    always_comb
    begin
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (in_fire)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (in_fire && produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (pixel_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= CFG_DATA_W'(1);
            height_cfg_reg <= CFG_DATA_W'(1);
            format_reg     <= FMT_BGRA32;
            gather_reg     <= '0;
            index_reg      <= '0;
            col_reg        <= '0;
            pad_reg        <= '0;
            src_row_reg    <= '0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data;
                    CFG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data;
                    CFG_PIXEL_FORMAT: format_reg     <= cfg_data[FMT_W-1:0];
                    default:          format_reg     <= format_reg;
                endcase
            end
            gather_reg    <= gather_next;
            index_reg     <= index_next;
            col_reg       <= col_next;
            pad_reg       <= pad_next;
            src_row_reg   <= src_row_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold payload until taken
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= data_byte;
        end
        if (in_fire && produce)
        begin
            pixel_word_reg <= pixel_calc;
            column_reg     <= col_ext[11:0];
            row_reg        <= row_ext[11:0];
            last_reg       <= col_last && row_last;
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel_word  = pixel_word_reg;
    assign column      = column_reg;
    assign row         = row_reg;
    assign last_pixel  = last_reg;

endmodule
